// ----- hdl/saq_pkg.sv -----
`default_nettype none
package saq_pkg;

  // Input component width; every other width here follows from the fixed
  // Q1.14 format and the fixed scaling target of the front end.
  localparam int IN_WIDTH   = 16;
  localparam int MAG_W      = (IN_WIDTH > 15) ? IN_WIDTH : 15;
  localparam int POS_W      = $clog2(MAG_W);
  localparam int SLOT_W     = 8;
  localparam int IN_TDATA_W = ((3 * IN_WIDTH + SLOT_W + 7) / 8) * 8;
  localparam int Q_W        = 16;
  localparam int OUT_TDATA_W = 4 * Q_W + SLOT_W;

  // Scaled component magnitudes lie in [0, 2^15).
  localparam int SC_W  = 15;
  localparam int SUM_W = 32;

  // Pipelined square root and divider units: one result bit per pipeline stage.
  localparam int SQ_IN_W   = 50;
  localparam int SQ_ROOT_W = 25;
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_Q_W   = 30;
  localparam int ALIGN     = DIV_Q_W - SQ_ROOT_W;

  localparam logic [Q_W-1:0] Q_ONE     = 16'h4000;
  localparam logic [Q_W-1:0] Q_NEG_ONE = 16'hC000;

  typedef struct packed {
    logic              zero;
    logic              negx;
    logic              negz;
    logic [SC_W-1:0]   magx;
    logic [SC_W-1:0]   magz;
    logic [15:0]       y;
    logic [SLOT_W-1:0] slot;
  } side_t;

endpackage
`default_nettype wire

// ----- hdl/shortest_arc_quat_from_up.sv -----
`default_nettype none
// Channel  Dir  Handshake                    Payload
// in_      in   in_tvalid / in_tready        in_tdata: target_x, target_y, target_z, slot
// out_     out  out_tvalid / out_tready      out_tdata: quat_w..quat_z, slot_out;
//                                            out_tuser: degenerate
//
// Fully pipelined: one transaction accepted per cycle while out_tready does not
// stall the pipe; a result passes through the front end, then the chain of
// bit-per-stage square root and divider units, then the output register.
// Reset (rst_n low, synchronous) clears the valid bits only.
// A stall on out_tready freezes every stage at once; nothing is lost or repeated.
module shortest_arc_quat_from_up (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // target_x, target_y, target_z, slot (lowest bits first)
  input  wire logic [saq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // quat_w, quat_x, quat_y, quat_z, slot_out (lowest bits first)
  output logic      [saq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // degenerate
  output logic                                    out_tuser
);
  import saq_pkg::*;

  logic adv;

  // Advance the whole pipe whenever the output register can take a result.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Front end: magnitudes, block scaling, sum of squares.
  logic             f_vld;
  side_t            f_side;
  logic [SUM_W-1:0] f_sum;

  saq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .vld_in   (in_tvalid),
    .tx       ($signed(in_tdata[IN_WIDTH-1:0])),
    .ty       ($signed(in_tdata[2*IN_WIDTH-1:IN_WIDTH])),
    .tz       ($signed(in_tdata[3*IN_WIDTH-1:2*IN_WIDTH])),
    .slot     (in_tdata[3*IN_WIDTH+SLOT_W-1:3*IN_WIDTH]),
    .vld_out  (f_vld),
    .side_out (f_side),
    .sum_out  (f_sum)
  );

  // Length with 8 fraction bits: L8 = sqrt(S * 2^16).
  logic [SQ_ROOT_W-1:0] root1;

  saq_sqrt u_sqrt_len (
    .clk  (clk),
    .en   (adv),
    .rad  ({2'b00, f_sum, 16'h0000}),
    .root (root1)
  );

  logic  vld_a_r  [SQ_ROOT_W];
  side_t side_a_r [SQ_ROOT_W];

  // Stage M1: P = L8 + 256*Y and the half-turn test.
  logic        m1_vld_r, m2_vld_r;
  side_t       m1_side_r, m2_side_r;
  logic [23:0] m1_l8_r, m2_l8_r;
  logic [24:0] m1_p_r;
  logic        m1_half_r, m2_half_r;
  logic [SQ_IN_W-1:0]   m2_prod_r;
  logic [DIV_NUM_W-1:0] m2_vnum_r;

  logic [23:0]        l8;
  logic signed [26:0] p_full;
  logic signed [35:0] hy, hl, hsum;
  logic [24:0]        p_nxt;
  logic [48:0]        mul;
  side_t              sa;

  always_comb begin
    sa     = side_a_r[SQ_ROOT_W-1];
    l8     = root1[23:0];
    p_full = $signed({3'b000, l8}) + ($signed(27'(signed'(sa.y))) <<< 8);
    hy     = 36'(signed'(sa.y)) * 36'sd256000;
    hl     = $signed({12'h000, l8}) * 36'sd999;
    hsum   = hy + hl;
    p_nxt  = (p_full[26] || p_full == '0) ? '0 : p_full[24:0];
    mul    = 49'(m1_l8_r) * 49'(m1_p_r);
  end

  // Parallel: D = sqrt(2*L8*P) and v = P*2^27 / L8.
  logic [SQ_ROOT_W-1:0] root2;
  logic [DIV_Q_W-1:0]   vquo;

  saq_sqrt u_sqrt_d (
    .clk  (clk),
    .en   (adv),
    .rad  (m2_prod_r),
    .root (root2)
  );

  saq_div u_div_w (
    .clk (clk),
    .en  (adv),
    .num (m2_vnum_r),
    .den (DIV_DEN_W'(m2_l8_r)),
    .quo (vquo)
  );

  logic                 vld_b_r  [DIV_Q_W];
  side_t                side_b_r [DIV_Q_W];
  logic                 half_b_r [DIV_Q_W];
  logic [SQ_ROOT_W-1:0] d_dly_r  [ALIGN];

  // Stage M3: dividends for the vector part and radicand for w.
  logic                 m3_vld_r;
  side_t                m3_side_r;
  logic                 m3_bad_r, m3_satx_r, m3_satz_r;
  logic [SQ_IN_W-1:0]   m3_rad_r;
  logic [DIV_NUM_W-1:0] m3_numx_r, m3_numz_r;
  logic [DIV_DEN_W-1:0] m3_d_r;

  side_t                sb;
  logic [SQ_ROOT_W-1:0] dval;
  logic [DIV_NUM_W-1:0] numx_nxt, numz_nxt, dlim;

  always_comb begin
    sb       = side_b_r[DIV_Q_W-1];
    dval     = d_dly_r[ALIGN-1];
    // quat_x comes from Z, quat_z from X
    numx_nxt = DIV_NUM_W'({sb.magz, 22'h000000}) + DIV_NUM_W'(dval[SQ_ROOT_W-1:1]);
    numz_nxt = DIV_NUM_W'({sb.magx, 22'h000000}) + DIV_NUM_W'(dval[SQ_ROOT_W-1:1]);
    dlim     = DIV_NUM_W'({dval, 15'h0000});
  end

  logic [SQ_ROOT_W-1:0] root3;
  logic [DIV_Q_W-1:0]   qx, qz;

  saq_sqrt u_sqrt_w (
    .clk  (clk),
    .en   (adv),
    .rad  (m3_rad_r),
    .root (root3)
  );

  saq_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (m3_numx_r),
    .den (m3_d_r),
    .quo (qx)
  );

  saq_div u_div_z (
    .clk (clk),
    .en  (adv),
    .num (m3_numz_r),
    .den (m3_d_r),
    .quo (qz)
  );

  logic                 vld_c_r  [DIV_Q_W];
  side_t                side_c_r [DIV_Q_W];
  logic                 bad_c_r  [DIV_Q_W];
  logic                 satx_c_r [DIV_Q_W];
  logic                 satz_c_r [DIV_Q_W];
  logic [SQ_ROOT_W-1:0] w_dly_r  [ALIGN];

  // Final assembly into the output register.
  side_t                sc;
  logic [SQ_ROOT_W:0]   wsum;
  logic [Q_W-1:0]       w_mag, x_mag, z_mag;
  logic [Q_W-1:0]       qw_nxt, qx_nxt, qz_nxt;
  logic [OUT_TDATA_W-1:0] tdata_nxt;
  logic                 tuser_nxt;

  always_comb begin
    sc    = side_c_r[DIV_Q_W-1];
    wsum  = (SQ_ROOT_W + 1)'(w_dly_r[ALIGN-1]) + 1'b1;
    w_mag = ((wsum >> 1) > (SQ_ROOT_W + 1)'(Q_ONE)) ? Q_ONE : Q_W'(wsum >> 1);
    x_mag = (satx_c_r[DIV_Q_W-1] || qx > DIV_Q_W'(Q_ONE)) ? Q_ONE : Q_W'(qx);
    z_mag = (satz_c_r[DIV_Q_W-1] || qz > DIV_Q_W'(Q_ONE)) ? Q_ONE : Q_W'(qz);
    qw_nxt = w_mag;
    qx_nxt = sc.negz ? (Q_W'(0) - x_mag) : x_mag;
    qz_nxt = sc.negx ? z_mag : (Q_W'(0) - z_mag);
    tuser_nxt = 1'b0;
    if (sc.zero) begin
      // zero vector: identity
      qw_nxt    = Q_ONE;
      qx_nxt    = '0;
      qz_nxt    = '0;
      tuser_nxt = 1'b1;
    end else if (bad_c_r[DIV_Q_W-1]) begin
      // nearly opposite to up: half turn about x
      qw_nxt = '0;
      qx_nxt = Q_NEG_ONE;
      qz_nxt = '0;
    end
    tdata_nxt = {sc.slot, qz_nxt, 16'h0000, qx_nxt, qw_nxt};
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_ROOT_W; k++) vld_a_r[k] <= 1'b0;
      for (int k = 0; k < DIV_Q_W; k++) begin
        vld_b_r[k] <= 1'b0;
        vld_c_r[k] <= 1'b0;
      end
      m1_vld_r   <= 1'b0;
      m2_vld_r   <= 1'b0;
      m3_vld_r   <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (adv) begin
      vld_a_r[0] <= f_vld;
      for (int k = 1; k < SQ_ROOT_W; k++) vld_a_r[k] <= vld_a_r[k-1];
      m1_vld_r   <= vld_a_r[SQ_ROOT_W-1];
      m2_vld_r   <= m1_vld_r;
      vld_b_r[0] <= m2_vld_r;
      for (int k = 1; k < DIV_Q_W; k++) vld_b_r[k] <= vld_b_r[k-1];
      m3_vld_r   <= vld_b_r[DIV_Q_W-1];
      vld_c_r[0] <= m3_vld_r;
      for (int k = 1; k < DIV_Q_W; k++) vld_c_r[k] <= vld_c_r[k-1];
      out_tvalid <= vld_c_r[DIV_Q_W-1];
    end
  end

  // Payload: hold on stall, advance otherwise.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_a_r[0] <= f_side;
      for (int k = 1; k < SQ_ROOT_W; k++) side_a_r[k] <= side_a_r[k-1];

      m1_side_r <= sa;
      m1_l8_r   <= l8;
      m1_p_r    <= p_nxt;
      m1_half_r <= hsum[35];

      m2_side_r <= m1_side_r;
      m2_l8_r   <= m1_l8_r;
      m2_half_r <= m1_half_r;
      m2_prod_r <= {mul, 1'b0};
      m2_vnum_r <= {m1_p_r, 27'h0000000};

      side_b_r[0] <= m2_side_r;
      half_b_r[0] <= m2_half_r;
      for (int k = 1; k < DIV_Q_W; k++) begin
        side_b_r[k] <= side_b_r[k-1];
        half_b_r[k] <= half_b_r[k-1];
      end
      d_dly_r[0] <= root2;
      for (int k = 1; k < ALIGN; k++) d_dly_r[k] <= d_dly_r[k-1];

      m3_side_r <= sb;
      m3_bad_r  <= half_b_r[DIV_Q_W-1] || (dval == '0);
      m3_satx_r <= (numx_nxt >= dlim);
      m3_satz_r <= (numz_nxt >= dlim);
      m3_rad_r  <= SQ_IN_W'({vquo, 2'b00});
      m3_numx_r <= numx_nxt;
      m3_numz_r <= numz_nxt;
      m3_d_r    <= dval;

      side_c_r[0] <= m3_side_r;
      bad_c_r[0]  <= m3_bad_r;
      satx_c_r[0] <= m3_satx_r;
      satz_c_r[0] <= m3_satz_r;
      for (int k = 1; k < DIV_Q_W; k++) begin
        side_c_r[k] <= side_c_r[k-1];
        bad_c_r[k]  <= bad_c_r[k-1];
        satx_c_r[k] <= satx_c_r[k-1];
        satz_c_r[k] <= satz_c_r[k-1];
      end
      w_dly_r[0] <= root3;
      for (int k = 1; k < ALIGN; k++) w_dly_r[k] <= w_dly_r[k-1];

      out_tdata <= tdata_nxt;
      out_tuser <= tuser_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/saq_sqrt.sv -----
`default_nettype none
module saq_sqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [saq_pkg::SQ_IN_W-1:0]   rad,
  output logic      [saq_pkg::SQ_ROOT_W-1:0] root
);
  import saq_pkg::*;

  localparam int RW = SQ_IN_W + 1;

  logic [SQ_IN_W-1:0] rem_r [SQ_ROOT_W];
  logic [RW-1:0]      acc_r [SQ_ROOT_W];

  // One root bit per stage: bit weight 4^(SQ_ROOT_W-1-k).
  for (genvar gk = 0; gk < SQ_ROOT_W; gk++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_ROOT_W - 1 - gk));
    logic [SQ_IN_W-1:0] rem_in;
    logic [RW-1:0]      acc_in;
    logic [RW:0]        trial;
    logic [SQ_IN_W-1:0] rem_nxt;
    logic [RW-1:0]      acc_nxt;

    if (gk == 0) begin : g_first
      assign rem_in = rad;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[gk-1];
      assign acc_in = acc_r[gk-1];
    end

    always_comb begin
      trial = {1'b0, acc_in} + {1'b0, BIT};
      if ((RW + 1)'(rem_in) >= trial) begin
        rem_nxt = rem_in - trial[SQ_IN_W-1:0];
        acc_nxt = (acc_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        acc_nxt = acc_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gk] <= rem_nxt;
        acc_r[gk] <= acc_nxt;
      end
    end
  end

  assign root = acc_r[SQ_ROOT_W-1][SQ_ROOT_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/saq_div.sv -----
`default_nettype none
module saq_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [saq_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [saq_pkg::DIV_DEN_W-1:0] den,
  output logic      [saq_pkg::DIV_Q_W-1:0]   quo
);
  import saq_pkg::*;

  localparam int SH_W = DIV_DEN_W + DIV_Q_W;

  logic [DIV_NUM_W-1:0] rem_r [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_r [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_r   [DIV_Q_W];

  // Restoring division, most significant quotient bit first.
  for (genvar gk = 0; gk < DIV_Q_W; gk++) begin : g_stage
    localparam int SH = DIV_Q_W - 1 - gk;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   q_in;
    logic [SH_W-1:0]      sub;
    logic [DIV_NUM_W-1:0] rem_nxt;
    logic [DIV_Q_W-1:0]   q_nxt;

    if (gk == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[gk-1];
      assign den_in = den_r[gk-1];
      assign q_in   = q_r[gk-1];
    end

    always_comb begin
      sub = SH_W'(den_in) << SH;
      if (SH_W'(rem_in) >= sub) begin
        rem_nxt = rem_in - sub[DIV_NUM_W-1:0];
        q_nxt   = q_in | (DIV_Q_W'(1) << SH);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gk] <= rem_nxt;
        den_r[gk] <= den_in;
        q_r[gk]   <= q_nxt;
      end
    end
  end

  assign quo = q_r[DIV_Q_W-1];

endmodule
`default_nettype wire

// ----- hdl/saq_front.sv -----
`default_nettype none
module saq_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               vld_in,
  input  wire logic signed [saq_pkg::IN_WIDTH-1:0] tx,
  input  wire logic signed [saq_pkg::IN_WIDTH-1:0] ty,
  input  wire logic signed [saq_pkg::IN_WIDTH-1:0] tz,
  input  wire logic        [saq_pkg::SLOT_W-1:0]   slot,
  output logic                                    vld_out,
  output saq_pkg::side_t                          side_out,
  output logic             [saq_pkg::SUM_W-1:0]    sum_out
);
  import saq_pkg::*;

  // Stage 1: magnitudes, signs, maximum.
  logic              v1_r;
  logic [MAG_W-1:0]  mx_r, my_r, mz_r, mm_r;
  logic              nx1_r, ny1_r, nz1_r;
  logic [SLOT_W-1:0] slot1_r;
  logic [MAG_W-1:0]  mx_nxt, my_nxt, mz_nxt, mm_nxt;

  function automatic logic [MAG_W-1:0] mag_of(input logic [IN_WIDTH-1:0] raw);
    logic [IN_WIDTH-1:0] a;
    a = raw[IN_WIDTH-1] ? (IN_WIDTH'(0) - raw) : raw;
    return MAG_W'(a);
  endfunction

  always_comb begin
    mx_nxt = mag_of($unsigned(tx));
    my_nxt = mag_of($unsigned(ty));
    mz_nxt = mag_of($unsigned(tz));
    mm_nxt = (mx_nxt > my_nxt) ? mx_nxt : my_nxt;
    if (mz_nxt > mm_nxt) mm_nxt = mz_nxt;
  end

  // Stage 2: block scaling so the largest magnitude lands in [2^14, 2^15).
  logic             v2_r;
  side_t            side2_r;
  logic [SC_W-1:0]  sy2_r;
  logic             ny2_r;
  logic [POS_W-1:0] msb;
  logic [SC_W-1:0]  sx_nxt, sy_nxt, sz_nxt;
  logic [15:0]      yext;

  always_comb begin
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mm_r[i]) msb = POS_W'(i);
    end
    if (msb >= POS_W'(14)) begin
      sx_nxt = SC_W'(mx_r >> (msb - POS_W'(14)));
      sy_nxt = SC_W'(my_r >> (msb - POS_W'(14)));
      sz_nxt = SC_W'(mz_r >> (msb - POS_W'(14)));
    end else begin
      sx_nxt = mx_r[SC_W-1:0] << (POS_W'(14) - msb);
      sy_nxt = my_r[SC_W-1:0] << (POS_W'(14) - msb);
      sz_nxt = mz_r[SC_W-1:0] << (POS_W'(14) - msb);
    end
  end

  // Stage 3: squares.
  logic            v3_r;
  side_t           side3_r;
  logic [2*SC_W-1:0] qx_r, qy_r, qz_r;

  // Stage 4: sum of squares.
  logic            v4_r;
  side_t           side4_r;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r    <= mx_nxt;
      my_r    <= my_nxt;
      mz_r    <= mz_nxt;
      mm_r    <= mm_nxt;
      nx1_r   <= tx[IN_WIDTH-1];
      ny1_r   <= ty[IN_WIDTH-1];
      nz1_r   <= tz[IN_WIDTH-1];
      slot1_r <= slot;

      side2_r.zero <= (mm_r == '0);
      side2_r.negx <= nx1_r;
      side2_r.negz <= nz1_r;
      side2_r.magx <= sx_nxt;
      side2_r.magz <= sz_nxt;
      side2_r.y    <= '0;
      side2_r.slot <= slot1_r;
      sy2_r        <= sy_nxt;
      ny2_r        <= ny1_r;

      side3_r   <= {side2_r.zero, side2_r.negx, side2_r.negz, side2_r.magx,
                    side2_r.magz, yext, side2_r.slot};
      qx_r      <= side2_r.magx * side2_r.magx;
      qy_r      <= sy2_r * sy2_r;
      qz_r      <= side2_r.magz * side2_r.magz;

      side4_r <= side3_r;
      sum_r   <= SUM_W'(qx_r) + SUM_W'(qy_r) + SUM_W'(qz_r);
    end
  end

  assign yext = ny2_r ? (16'd0 - {1'b0, sy2_r}) : {1'b0, sy2_r};

  assign vld_out  = v4_r;
  assign side_out = side4_r;
  assign sum_out  = sum_r;

endmodule
`default_nettype wire
